@@ sv/assert_macros.svh @@
// Assertion macros shared by the fade envelope RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/afe_pkg.sv @@
// Types, constants and microprogram of the fade envelope
`default_nettype none

package afe_pkg;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int GAIN_CFG_W  = 16;
    localparam int GAIN_W      = 32;
    localparam int X_W         = 17;
    localparam int PROD_FRAC   = 30;
    localparam int CUBE_SHIFT  = 32;
    localparam int DIV_STEPS   = 16;
    localparam int CNT_W       = 4;
    localparam int STEP_W      = 4;

    localparam logic [X_W-1:0] X_ONE = 17'h10000;

    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_START  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_END    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FADE_LENGTH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_EASE_MODE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BYPASS      = 3'd4;

    typedef enum logic [1:0] {
        EASE_LINEAR    = 2'd0,
        EASE_CUBIC_IN  = 2'd1,
        EASE_CUBIC_OUT = 2'd2,
        EASE_IN_OUT    = 2'd3
    } ease_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV,
        OP_SEL_T,
        OP_SQUARE,
        OP_CUBE,
        OP_EASE,
        OP_GAIN_LO,
        OP_GAIN_HI,
        OP_GAIN_SUM,
        OP_APPLY,
        OP_RESULT
    } op_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_JUMP,
        C_WAIT_IN,
        C_WAIT_OUT,
        C_BYPASS,
        C_DONE,
        C_DIV_MORE,
        C_LINEAR
    } cond_t;

    localparam logic [STEP_W-1:0] STEP_IDLE     = 4'd0;
    localparam logic [STEP_W-1:0] STEP_BYP_CHK  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_DONE_CHK = 4'd2;
    localparam logic [STEP_W-1:0] STEP_DIV      = 4'd3;
    localparam logic [STEP_W-1:0] STEP_SHAPE    = 4'd4;
    localparam logic [STEP_W-1:0] STEP_SQUARE   = 4'd5;
    localparam logic [STEP_W-1:0] STEP_CUBE     = 4'd6;
    localparam logic [STEP_W-1:0] STEP_EASE     = 4'd7;
    localparam logic [STEP_W-1:0] STEP_GAIN_LO  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_GAIN_HI  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_GAIN_SUM = 4'd10;
    localparam logic [STEP_W-1:0] STEP_APPLY    = 4'd11;
    localparam logic [STEP_W-1:0] STEP_FINISH   = 4'd12;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        op_t  op;
        logic fire;
    } ctrl_t;

    typedef struct packed {
        logic bypass;
        logic done;
        logic div_more;
        logic linear;
        logic out_busy;
    } status_t;

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        unique case (step)
            STEP_IDLE:     w = '{op: OP_LOAD,     cond: C_WAIT_IN,  target: STEP_IDLE};
            STEP_BYP_CHK:  w = '{op: OP_NOP,      cond: C_BYPASS,   target: STEP_FINISH};
            STEP_DONE_CHK: w = '{op: OP_NOP,      cond: C_DONE,     target: STEP_SHAPE};
            STEP_DIV:      w = '{op: OP_DIV,      cond: C_DIV_MORE, target: STEP_DIV};
            STEP_SHAPE:    w = '{op: OP_SEL_T,    cond: C_LINEAR,   target: STEP_GAIN_LO};
            STEP_SQUARE:   w = '{op: OP_SQUARE,   cond: C_NEXT,     target: STEP_IDLE};
            STEP_CUBE:     w = '{op: OP_CUBE,     cond: C_NEXT,     target: STEP_IDLE};
            STEP_EASE:     w = '{op: OP_EASE,     cond: C_NEXT,     target: STEP_IDLE};
            STEP_GAIN_LO:  w = '{op: OP_GAIN_LO,  cond: C_NEXT,     target: STEP_IDLE};
            STEP_GAIN_HI:  w = '{op: OP_GAIN_HI,  cond: C_NEXT,     target: STEP_IDLE};
            STEP_GAIN_SUM: w = '{op: OP_GAIN_SUM, cond: C_NEXT,     target: STEP_IDLE};
            STEP_APPLY:    w = '{op: OP_APPLY,    cond: C_NEXT,     target: STEP_IDLE};
            STEP_FINISH:   w = '{op: OP_RESULT,   cond: C_WAIT_OUT, target: STEP_IDLE};
            default:       w = '{op: OP_NOP,      cond: C_JUMP,     target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ sv/audio_fade_envelope.sv @@
// Fade envelope top level: configuration registers, sequencer and datapath
//
// Applies a gain that moves from gain_start to gain_end over fade_length samples,
// shaped linear, cubic-in, cubic-out or cubic-in-out, to one Q1.23 sample per item,
// saturating the result. Items are processed one at a time by a microprogrammed
// datapath: a restoring divider producing one progress bit per cycle and a single
// shared multiplier set the timing. The divider steps are skipped once the fade is
// complete, the cubic steps with the linear curve and all arithmetic steps in bypass.
// A finished result waits in an output register, so the next item is taken while it
// is still held. Configuration writes are taken every cycle and are meant for idle
// periods only.
`default_nettype none

`include "assert_macros.svh"

module audio_fade_envelope import afe_pkg::*; #(
    parameter int SAMPLE_BITS = 24,
    parameter int LENGTH_BITS = 24
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]        cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         cfg_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] s_sample_in,
    input  wire logic                          s_restart,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0]      m_sample_out,
    output logic                               m_fade_complete
);

    logic [GAIN_CFG_W-1:0]  gain_start_reg, gain_start_next;
    logic [GAIN_CFG_W-1:0]  gain_end_reg, gain_end_next;
    logic [LENGTH_BITS-1:0] fade_length_reg, fade_length_next;
    ease_t                  ease_mode_reg, ease_mode_next;
    logic                   bypass_reg, bypass_next;
    ctrl_t                  ctrl;
    status_t                status;

    assign cfg_ready = 1'b1;

    always_comb begin
        gain_start_next  = gain_start_reg;
        gain_end_next    = gain_end_reg;
        fade_length_next = fade_length_reg;
        ease_mode_next   = ease_mode_reg;
        bypass_next      = bypass_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_GAIN_START:  gain_start_next  = cfg_data[GAIN_CFG_W-1:0];
                REG_GAIN_END:    gain_end_next    = cfg_data[GAIN_CFG_W-1:0];
                REG_FADE_LENGTH: fade_length_next = cfg_data[LENGTH_BITS-1:0];
                REG_EASE_MODE:   ease_mode_next   = ease_t'(cfg_data[1:0]);
                REG_BYPASS:      bypass_next      = cfg_data[0];
                default:         bypass_next      = bypass_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_start_reg  <= '0;
            gain_end_reg    <= GAIN_CFG_W'(16384);
            fade_length_reg <= '0;
            ease_mode_reg   <= EASE_LINEAR;
            bypass_reg      <= 1'b0;
        end else begin
            gain_start_reg  <= gain_start_next;
            gain_end_reg    <= gain_end_next;
            fade_length_reg <= fade_length_next;
            ease_mode_reg   <= ease_mode_next;
            bypass_reg      <= bypass_next;
        end
    end

    afe_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .status   (status),
        .ctrl     (ctrl)
    );

    afe_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctrl            (ctrl),
        .status          (status),
        .s_sample_in     (s_sample_in),
        .s_restart       (s_restart),
        .gain_start      (gain_start_reg),
        .gain_end        (gain_end_reg),
        .fade_length     (fade_length_reg),
        .ease_mode       (ease_mode_reg),
        .bypass          (bypass_reg),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_sample_out    (m_sample_out),
        .m_fade_complete (m_fade_complete)
    );

    `ASSERT_NXT(a_top_one_item_in_flight, aclk, aresetn,
        s_valid && s_ready,
        !s_ready, "second item accepted while one is in progress")

endmodule

`default_nettype wire

@@ sv/afe_seq.sv @@
// Microprogram sequencer: step counter, control store and branch logic
`default_nettype none

`include "assert_macros.svh"

module afe_seq import afe_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t status,
    output ctrl_t        ctrl
);

    logic [STEP_W-1:0] step_reg, step_next;
    ucode_t            uw;
    logic              fire;
    logic              take;

    assign uw = ucode_rom(step_reg);

    always_comb begin
        fire = 1'b1;
        take = 1'b0;
        unique case (uw.cond)
            C_NEXT:     take = 1'b0;
            C_JUMP:     take = 1'b1;
            C_WAIT_IN:  fire = in_valid;
            C_WAIT_OUT: begin
                fire = !status.out_busy;
                take = 1'b1;
            end
            C_BYPASS:   take = status.bypass;
            C_DONE:     take = status.done;
            C_DIV_MORE: take = status.div_more;
            C_LINEAR:   take = status.linear;
        endcase

        if (!fire) begin
            step_next = step_reg;
        end else if (take) begin
            step_next = uw.target;
        end else begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

    assign in_ready  = (uw.cond == C_WAIT_IN);
    assign ctrl.op   = uw.op;
    assign ctrl.fire = fire;

    `ASSERT_NXT(a_seq_hold_on_busy, aclk, aresetn,
        (uw.cond == C_WAIT_OUT) && status.out_busy,
        step_reg == $past(step_reg), "sequencer left result step while output busy")

endmodule

`default_nettype wire

@@ sv/afe_dp.sv @@
// Datapath: divider step, shared multiplier, shaping, gain and saturation
`default_nettype none

`include "assert_macros.svh"

module afe_dp import afe_pkg::*; #(
    parameter int SAMPLE_BITS = 24,
    parameter int LENGTH_BITS = 24
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire ctrl_t                         ctrl,
    output status_t                            status,
    input  wire logic signed [SAMPLE_BITS-1:0] s_sample_in,
    input  wire logic                          s_restart,
    input  wire logic [GAIN_CFG_W-1:0]         gain_start,
    input  wire logic [GAIN_CFG_W-1:0]         gain_end,
    input  wire logic [LENGTH_BITS-1:0]        fade_length,
    input  wire ease_t                         ease_mode,
    input  wire logic                          bypass,
    input  wire logic                          m_ready,
    output logic                               m_valid,
    output logic signed [SAMPLE_BITS-1:0]      m_sample_out,
    output logic                               m_fade_complete
);

    localparam int MUL_A_W = (SAMPLE_BITS > 2 * X_W - 1) ? SAMPLE_BITS : 2 * X_W - 1;
    localparam int PROD_W  = MUL_A_W + GAIN_W;
    localparam int Q_W     = PROD_W + 1 - PROD_FRAC;
    localparam logic [PROD_W:0] RND_BIAS = (PROD_W + 1)'((64'd1 << PROD_FRAC) - 64'd1);
    localparam logic [Q_W-1:0]  POS_MAX  = Q_W'({(SAMPLE_BITS - 1){1'b1}});
    localparam logic [Q_W-1:0]  NEG_MAX  = Q_W'(1) << (SAMPLE_BITS - 1);

    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic [SAMPLE_BITS-1:0]        mag_reg, mag_next;
    logic                          neg_reg, neg_next;
    logic [LENGTH_BITS-1:0]        elapsed_reg, elapsed_next;
    logic [LENGTH_BITS-1:0]        rem_reg, rem_next;
    logic [LENGTH_BITS-1:0]        elapsed_eff;
    logic [LENGTH_BITS:0]          rem_dbl, rem_sub;
    logic                          rem_ge;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          done_reg, done_next;
    logic [X_W-1:0]                x_reg, x_next;
    logic [X_W-1:0]                t_reg, t_next;
    logic [X_W-1:0]                e_reg, e_next;
    logic [X_W-1:0]                cube_sh;
    logic                          inv_reg, inv_next;
    logic                          sh33_reg, sh33_next;
    logic [GAIN_W-1:0]             g_reg, g_next;
    logic [PROD_W-1:0]             prod_reg, prod_next;
    logic [MUL_A_W-1:0]            mul_a;
    logic [GAIN_W-1:0]             mul_b;
    logic [PROD_W-1:0]             mul_p;
    logic [PROD_W:0]               rnd_sum;
    logic [Q_W-1:0]                q_mag;
    logic [SAMPLE_BITS-1:0]        sat_val;
    logic                          x_lt_half;
    logic                          m_valid_reg, m_valid_next;
    logic [SAMPLE_BITS-1:0]        m_sample_reg, m_sample_next;
    logic                          m_done_reg, m_done_next;

    assign elapsed_eff = s_restart ? '0 : elapsed_reg;
    assign rem_dbl     = {rem_reg, 1'b0};
    assign rem_ge      = rem_dbl >= {1'b0, fade_length};
    assign rem_sub     = rem_dbl - {1'b0, fade_length};
    assign x_lt_half   = !x_reg[X_W-1] && !x_reg[X_W-2];
    assign cube_sh     = sh33_reg ? prod_reg[CUBE_SHIFT + 1 +: X_W] : prod_reg[CUBE_SHIFT +: X_W];

    // shared multiplier operand select
    always_comb begin
        mul_a = MUL_A_W'(mag_reg);
        mul_b = g_reg;
        unique case (ctrl.op)
            OP_SQUARE: begin
                mul_a = MUL_A_W'(t_reg);
                mul_b = GAIN_W'(t_reg);
            end
            OP_CUBE: begin
                mul_a = MUL_A_W'(prod_reg[2 * X_W - 2:0]);
                mul_b = GAIN_W'(t_reg);
            end
            OP_GAIN_LO: begin
                mul_a = MUL_A_W'(gain_start);
                mul_b = GAIN_W'(X_ONE - e_reg);
            end
            OP_GAIN_HI: begin
                mul_a = MUL_A_W'(gain_end);
                mul_b = GAIN_W'(e_reg);
            end
            default: begin
                mul_a = MUL_A_W'(mag_reg);
                mul_b = g_reg;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // round towards minus infinity, then saturate
    assign rnd_sum = {1'b0, prod_reg} + RND_BIAS;
    assign q_mag   = neg_reg ? rnd_sum[PROD_W:PROD_FRAC] : {1'b0, prod_reg[PROD_W-1:PROD_FRAC]};

    always_comb begin
        if (!neg_reg) begin
            sat_val = (q_mag > POS_MAX) ? POS_MAX[SAMPLE_BITS-1:0] : q_mag[SAMPLE_BITS-1:0];
        end else begin
            sat_val = (q_mag > NEG_MAX) ? NEG_MAX[SAMPLE_BITS-1:0]
                                        : (~q_mag[SAMPLE_BITS-1:0] + 1'b1);
        end
    end

    always_comb begin
        sample_next   = sample_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        elapsed_next  = elapsed_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        done_next     = done_reg;
        x_next        = x_reg;
        t_next        = t_reg;
        e_next        = e_reg;
        inv_next      = inv_reg;
        sh33_next     = sh33_reg;
        g_next        = g_reg;
        prod_next     = prod_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_sample_next = m_sample_reg;
        m_done_next   = m_done_reg;

        if (ctrl.fire) begin
            unique case (ctrl.op)
                OP_LOAD: begin
                    sample_next  = s_sample_in;
                    neg_next     = s_sample_in[SAMPLE_BITS-1];
                    mag_next     = s_sample_in[SAMPLE_BITS-1] ? SAMPLE_BITS'(-s_sample_in)
                                                              : SAMPLE_BITS'(s_sample_in);
                    elapsed_next = elapsed_eff;
                    rem_next     = elapsed_eff;
                    done_next    = elapsed_eff >= fade_length;
                    cnt_next     = CNT_W'(DIV_STEPS - 1);
                    x_next       = X_ONE;
                end
                OP_DIV: begin
                    rem_next = rem_ge ? rem_sub[LENGTH_BITS-1:0] : rem_dbl[LENGTH_BITS-1:0];
                    x_next   = {x_reg[X_W-2:0], rem_ge};
                    cnt_next = cnt_reg - 1'b1;
                end
                OP_SEL_T: begin
                    e_next    = x_reg;
                    inv_next  = 1'b0;
                    sh33_next = 1'b0;
                    t_next    = x_reg;
                    unique case (ease_mode)
                        EASE_LINEAR:   t_next = x_reg;
                        EASE_CUBIC_IN: t_next = x_reg;
                        EASE_CUBIC_OUT: begin
                            t_next   = X_ONE - x_reg;
                            inv_next = 1'b1;
                        end
                        EASE_IN_OUT: begin
                            sh33_next = 1'b1;
                            if (x_lt_half) begin
                                t_next = {x_reg[X_W-2:0], 1'b0};
                            end else begin
                                t_next   = X_W'({X_ONE - x_reg, 1'b0});
                                inv_next = 1'b1;
                            end
                        end
                    endcase
                end
                OP_SQUARE, OP_CUBE, OP_GAIN_LO, OP_APPLY: begin
                    prod_next = mul_p;
                end
                OP_EASE: begin
                    e_next = inv_reg ? (X_ONE - cube_sh) : cube_sh;
                end
                OP_GAIN_HI: begin
                    g_next    = prod_reg[GAIN_W-1:0];
                    prod_next = mul_p;
                end
                OP_GAIN_SUM: begin
                    g_next = g_reg + prod_reg[GAIN_W-1:0];
                end
                OP_RESULT: begin
                    m_valid_next  = 1'b1;
                    m_done_next   = done_reg;
                    m_sample_next = bypass ? SAMPLE_BITS'(sample_reg) : sat_val;
                    if (!done_reg && !bypass) begin
                        elapsed_next = elapsed_reg + 1'b1;
                    end
                end
                default: begin
                    m_done_next = m_done_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elapsed_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            elapsed_reg <= elapsed_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg   <= sample_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        done_reg     <= done_next;
        x_reg        <= x_next;
        t_reg        <= t_next;
        e_reg        <= e_next;
        inv_reg      <= inv_next;
        sh33_reg     <= sh33_next;
        g_reg        <= g_next;
        prod_reg     <= prod_next;
        m_sample_reg <= m_sample_next;
        m_done_reg   <= m_done_next;
    end

    assign status.bypass   = bypass;
    assign status.done     = done_reg;
    assign status.div_more = (cnt_reg != '0);
    assign status.linear   = (ease_mode == EASE_LINEAR);
    assign status.out_busy = m_valid_reg && !m_ready;

    assign m_valid         = m_valid_reg;
    assign m_sample_out    = m_sample_reg;
    assign m_fade_complete = m_done_reg;

    `ASSERT_IMP(a_dp_rem_below_len, aclk, aresetn,
        ctrl.fire && (ctrl.op == OP_DIV),
        rem_reg < fade_length, "divider remainder not below fade length")

    `ASSERT_NXT(a_dp_ease_in_range, aclk, aresetn,
        ctrl.fire && (ctrl.op == OP_EASE),
        e_reg <= X_ONE, "eased progress above unity")

endmodule

`default_nettype wire

@@ bench/tb_audio_fade_envelope.sv @@
// Self-checking testbench for the audio fade envelope: directed cases, random fades, backpressure
module tb_audio_fade_envelope;
    timeunit 1ns;
    timeprecision 1ps;

    import afe_pkg::*;

    localparam int SAMPLE_W        = 24;
    localparam int LEN_W           = 24;
    localparam int ITEMS_PER_PHASE = 600;
    localparam int HOLD_CYCLES     = 300;
    localparam int STALL_LIMIT     = 4000;
    localparam int SETTLE_CYCLES   = 64;
    localparam int MAX_REPORTS     = 40;

    localparam logic [16:0] PROGRESS_ONE  = 17'h10000;
    localparam logic [16:0] PROGRESS_HALF = 17'h08000;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       complete;
    } fade_result_t;

    logic                       aclk            = 1'b0;
    logic                       aresetn         = 1'b0;
    logic                       cfg_valid       = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_W-1:0]     cfg_index       = '0;
    logic [CFG_DATA_W-1:0]      cfg_data        = '0;
    logic                       s_valid         = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample_in     = '0;
    logic                       s_restart       = 1'b0;
    logic                       m_valid;
    logic                       m_ready         = 1'b0;
    logic signed [SAMPLE_W-1:0] m_sample_out;
    logic                       m_fade_complete;

    // envelope state as the block should hold it
    logic [15:0]      env_gain_start;
    logic [15:0]      env_gain_end;
    logic [LEN_W-1:0] env_fade_len;
    ease_t            env_ease;
    logic             env_bypass;
    logic [LEN_W-1:0] env_elapsed;

    fade_result_t pending_fades[$];

    int mismatches     = 0;
    int send_idle_pct  = 24;
    int recv_stall_pct = 71;
    int holds_asked    = 0;
    int holds_seen     = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    audio_fade_envelope #(
        .SAMPLE_BITS(SAMPLE_W),
        .LENGTH_BITS(LEN_W)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_in    (s_sample_in),
        .s_restart      (s_restart),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample_out   (m_sample_out),
        .m_fade_complete(m_fade_complete)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [16:0] shape_progress(input logic [16:0] x, input ease_t mode);
        logic [63:0] t;
        case (mode)
            EASE_CUBIC_IN: begin
                t = 64'(x);
                return 17'((t * t * t) >> 32);
            end
            EASE_CUBIC_OUT: begin
                t = 64'(PROGRESS_ONE - x);
                return PROGRESS_ONE - 17'((t * t * t) >> 32);
            end
            EASE_IN_OUT: begin
                if (x < PROGRESS_HALF) begin
                    t = 64'(x) * 2;
                    return 17'((t * t * t) >> 33);
                end
                t = 64'(PROGRESS_ONE - x) * 2;
                return PROGRESS_ONE - 17'((t * t * t) >> 33);
            end
            default: return x;
        endcase
    endfunction

    // returns what the block should emit; advances the count unless bypassed or complete
    function automatic fade_result_t predict_fade(input logic signed [SAMPLE_W-1:0] smp,
                                                  input logic rst);
        fade_result_t r;
        logic [16:0]  x;
        logic [16:0]  e;
        logic [31:0]  g;
        longint       p;
        if (rst) begin
            env_elapsed = '0;
        end
        r.complete = (env_elapsed >= env_fade_len);
        if (env_bypass) begin
            r.sample = smp;
            return r;
        end
        if (r.complete) begin
            x = PROGRESS_ONE;
        end else begin
            x = 17'((48'(env_elapsed) << 16) / env_fade_len);
        end
        e = shape_progress(x, env_ease);
        g = 32'(env_gain_start) * 32'(PROGRESS_ONE - e) + 32'(env_gain_end) * 32'(e);
        p = (longint'(smp) * longint'(g)) >>> 30;
        if (p > longint'(SAMPLE_MAX)) begin
            p = longint'(SAMPLE_MAX);
        end else if (p < longint'(SAMPLE_MIN)) begin
            p = longint'(SAMPLE_MIN);
        end
        r.sample = SAMPLE_W'(p);
        if (!r.complete) begin
            env_elapsed = env_elapsed + 1'b1;
        end
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(7))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2, 3: return SAMPLE_W'(int'($urandom_range(511)) - 256);
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return 16'h4000;
            default: return 16'($urandom());
        endcase
    endfunction

    // fills the unused upper bits of a register write with junk
    function automatic logic [CFG_DATA_W-1:0] noisy(input logic [CFG_DATA_W-1:0] value,
                                                   input int width);
        return ($urandom() << width) | value;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data, input logic drop_valid);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_GAIN_START:  env_gain_start = data[15:0];
            REG_GAIN_END:    env_gain_end   = data[15:0];
            REG_FADE_LENGTH: env_fade_len   = data[LEN_W-1:0];
            REG_EASE_MODE:   env_ease       = ease_t'(data[1:0]);
            REG_BYPASS:      env_bypass     = data[0];
            default: ;
        endcase
        if (drop_valid) begin
            cfg_valid <= 1'b0;
        end
    endtask

    task automatic send_item(input logic signed [SAMPLE_W-1:0] smp, input logic rst);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_sample_in <= smp;
        s_restart   <= rst;
        do @(posedge aclk); while (!s_ready);
        pending_fades.push_back(predict_fade(smp, rst));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_fades.size() != 0);
    endtask

    // reset values: zero length, so unity end gain applies at once
    task automatic test_reset_defaults();
        send_item(SAMPLE_MAX, 1'b0);
        send_item(SAMPLE_MIN, 1'b0);
        send_item('0, 1'b1);
        send_item('1, 1'b0);
    endtask

    // two-sample fade hits progress 0 and exactly one half on every curve
    task automatic test_ease_curves();
        ease_t mode;
        mode = EASE_LINEAR;
        wait_drained();
        write_reg(REG_GAIN_START, 32'd4096, 1'b0);
        write_reg(REG_GAIN_END, 32'd20000, 1'b0);
        write_reg(REG_FADE_LENGTH, 32'd2, 1'b1);
        repeat (4) begin
            wait_drained();
            write_reg(REG_EASE_MODE, CFG_DATA_W'(mode), 1'b1);
            send_item(SAMPLE_MAX, 1'b1);
            send_item(SAMPLE_MIN, 1'b0);
            mode = mode.next();
        end
    endtask

    task automatic test_saturation();
        wait_drained();
        write_reg(REG_GAIN_START, 32'hFFFF, 1'b0);
        write_reg(REG_GAIN_END, 32'hFFFF, 1'b0);
        write_reg(REG_FADE_LENGTH, 32'd0, 1'b1);
        send_item(SAMPLE_MAX, 1'b0);
        send_item(SAMPLE_MIN, 1'b0);
        send_item(SAMPLE_W'(1000), 1'b0);
    endtask

    // shortening the fade under the running count clamps progress at one
    task automatic test_length_lowered();
        wait_drained();
        write_reg(REG_EASE_MODE, CFG_DATA_W'(EASE_LINEAR), 1'b0);
        write_reg(REG_GAIN_START, 32'd0, 1'b0);
        write_reg(REG_GAIN_END, 32'd16384, 1'b0);
        write_reg(REG_FADE_LENGTH, 32'd6, 1'b1);
        send_item(random_sample(), 1'b1);
        repeat (3) send_item(random_sample(), 1'b0);
        wait_drained();
        write_reg(REG_FADE_LENGTH, 32'd2, 1'b1);
        send_item(random_sample(), 1'b0);
    endtask

    // count holds in bypass, restart still clears it
    task automatic test_bypass();
        wait_drained();
        write_reg(REG_BYPASS, 32'd1, 1'b1);
        send_item(random_sample(), 1'b0);
        send_item(random_sample(), 1'b1);
    endtask

    // spare indexes are ignored and bits above each field are dropped
    task automatic test_register_decode();
        wait_drained();
        for (int i = int'(REG_BYPASS) + 1; i < (1 << CFG_INDEX_W); i++) begin
            write_reg(CFG_INDEX_W'(i), $urandom(), 1'b0);
        end
        write_reg(REG_BYPASS, 32'hFFFF_FFFE, 1'b0);
        write_reg(REG_GAIN_START, 32'hFFFF_2000, 1'b0);
        write_reg(REG_GAIN_END, 32'hABCD_5000, 1'b0);
        write_reg(REG_EASE_MODE, 32'hFFFF_FFFC, 1'b0);
        write_reg(REG_FADE_LENGTH, 32'hFF00_0000, 1'b1);
        send_item(SAMPLE_MAX, 1'b0);
    endtask

    task automatic test_longest_fade();
        wait_drained();
        write_reg(REG_GAIN_START, 32'hFFFF, 1'b0);
        write_reg(REG_GAIN_END, 32'd0, 1'b0);
        write_reg(REG_EASE_MODE, CFG_DATA_W'(EASE_IN_OUT), 1'b0);
        write_reg(REG_FADE_LENGTH, 32'h00FF_FFFF, 1'b1);
        send_item(random_sample(), 1'b1);
        send_item(random_sample(), 1'b0);
    endtask

    // mostly complete fades from a restart, with the odd stray restart or carried count
    task automatic test_random_fades();
        int               sent;
        int               run_len;
        logic [LEN_W-1:0] len;
        sent = 0;
        while (sent < ITEMS_PER_PHASE) begin
            wait_drained();
            case ($urandom_range(19))
                0: len = '0;
                1: len = '1;
                2: len = LEN_W'($urandom());
                default: len = LEN_W'($urandom_range(40, 1));
            endcase
            write_reg(REG_GAIN_START, noisy(32'(pick_gain()), 16), 1'b0);
            write_reg(REG_GAIN_END, noisy(32'(pick_gain()), 16), 1'b0);
            write_reg(REG_FADE_LENGTH, noisy(32'(len), LEN_W), 1'b0);
            write_reg(REG_EASE_MODE, noisy(32'($urandom_range(3)), 2), 1'b0);
            write_reg(REG_BYPASS, noisy(32'($urandom_range(9) == 0), 1), 1'b1);
            if (len <= 48) begin
                run_len = int'(len) + $urandom_range(8, 1);
            end else begin
                run_len = $urandom_range(24, 4);
            end
            for (int k = 0; k < run_len; k++) begin
                send_item(random_sample(),
                          (k == 0 && $urandom_range(9) != 0) || $urandom_range(99) < 3);
            end
            sent += run_len;
        end
    endtask

    // receiver stops for a long stretch while the sender keeps offering
    task automatic test_output_backpressure();
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_reg(REG_BYPASS, 32'd0, 1'b0);
        write_reg(REG_GAIN_START, 32'd0, 1'b0);
        write_reg(REG_GAIN_END, 32'd40000, 1'b0);
        write_reg(REG_EASE_MODE, CFG_DATA_W'(EASE_CUBIC_OUT), 1'b0);
        write_reg(REG_FADE_LENGTH, 32'd32, 1'b1);
        holds_asked++;
        for (int k = 0; k < 40; k++) begin
            send_item(random_sample(), k == 0);
        end
    endtask

    always @(posedge aclk) begin
        if (holds_seen != holds_asked) begin
            holds_seen = holds_asked;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        fade_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_fades.size() == 0) begin
                flag_mismatch($sformatf("unexpected item, sample_out %0d fade_complete %0b",
                                        m_sample_out, m_fade_complete));
            end else begin
                want = pending_fades.pop_front();
                if (m_sample_out !== want.sample) begin
                    flag_mismatch($sformatf("sample_out %0d, expected %0d",
                                            m_sample_out, want.sample));
                end
                if (m_fade_complete !== want.complete) begin
                    flag_mismatch($sformatf("fade_complete %0b, expected %0b",
                                            m_fade_complete, want.complete));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("audio_fade_envelope verification failed");
            $finish;
        end else begin
            quiet_cycles++;
        end
    end

    initial begin
        env_gain_start = '0;
        env_gain_end   = 16'h4000;
        env_fade_len   = '0;
        env_ease       = EASE_LINEAR;
        env_bypass     = 1'b0;
        env_elapsed    = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_ease_curves();
        test_saturation();
        test_length_lowered();
        test_bypass();
        test_register_decode();
        test_longest_fade();

        send_idle_pct  = 24;
        recv_stall_pct = 71;
        test_random_fades();
        send_idle_pct  = 71;
        recv_stall_pct = 24;
        test_random_fades();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_fades();

        test_output_backpressure();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("audio_fade_envelope verification clean");
        end else begin
            $display("audio_fade_envelope verification failed");
        end
        $finish;
    end

endmodule
